>>> rtl/core/tfn_pkg.sv
// Shared widths, constants and sideband types for the triangle face normal block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;

   // default vertex coordinate width
   localparam int TFN_COORD_BITS   = 20;
   // normalized magnitude: top bit of the largest component at bit 30
   localparam int TFN_M_W          = 31;
   // sum of squares, integer square root
   localparam int TFN_S_W          = 64;
   localparam int TFN_L_W          = 32;
   localparam int TFN_SQRT_STAGES  = TFN_L_W;
   // Q1.14 output and the restoring divider
   localparam int TFN_FRAC         = 14;
   localparam int TFN_Q_W          = TFN_FRAC + 1;
   localparam int TFN_DIV_STAGES   = TFN_Q_W;
   localparam int TFN_DIV_W        = TFN_M_W + TFN_FRAC + 1;
   localparam int TFN_N_W          = 16;

   // per-item flags that ride along with the data
   typedef struct packed {
      logic       degen;
      logic [2:0] neg;
   } tfn_side_type;

   // normalized magnitudes plus flags
   typedef struct packed {
      tfn_side_type               side;
      logic [2:0][TFN_M_W-1:0]    m;
   } tfn_lane_type;

endpackage
`default_nettype wire

>>> rtl/core/tfn_cross.sv
// Edge vectors and exact cross product, three register stages.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfn_cross import tfn_pkg::*; #(
   parameter int COORD_BITS = TFN_COORD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_vld,
   input  logic [9*COORD_BITS-1:0]   in_coords,
   output logic                      out_vld,
   output logic [2*COORD_BITS+2:0]   out_mag [3],
   output logic [2:0]                out_neg
);
   localparam int E_W = COORD_BITS + 1;
   localparam int P_W = 2 * E_W;
   localparam int C_W = P_W + 1;

   logic signed [E_W-1:0] e1_in [3];
   logic signed [E_W-1:0] e2_in [3];
   logic signed [E_W-1:0] e1_ff [3];
   logic signed [E_W-1:0] e2_ff [3];
   logic signed [P_W-1:0] p_in  [6];
   logic signed [P_W-1:0] p_ff  [6];
   logic        [C_W-1:0] c_in  [3];
   logic        [C_W-1:0] mag_in [3];
   logic        [C_W-1:0] mag_ff [3];
   logic        [2:0]     neg_ff;
   logic        [2:0]     vld_ff;

   // edges b - a and c - a, one bit wider than the coordinates
   always_comb begin
      logic [COORD_BITS-1:0] va, vb, vc;
      for (int k = 0; k < 3; k++) begin
         va = in_coords[k*COORD_BITS +: COORD_BITS];
         vb = in_coords[(3+k)*COORD_BITS +: COORD_BITS];
         vc = in_coords[(6+k)*COORD_BITS +: COORD_BITS];
         e1_in[k] = {vb[COORD_BITS-1], vb} - {va[COORD_BITS-1], va};
         e2_in[k] = {vc[COORD_BITS-1], vc} - {va[COORD_BITS-1], va};
      end
   end

   // six signed partial products of the cross product
   always_comb begin
      p_in[0] = e1_ff[1] * e2_ff[2];
      p_in[1] = e1_ff[2] * e2_ff[1];
      p_in[2] = e1_ff[2] * e2_ff[0];
      p_in[3] = e1_ff[0] * e2_ff[2];
      p_in[4] = e1_ff[0] * e2_ff[1];
      p_in[5] = e1_ff[1] * e2_ff[0];
   end

   // differences, then sign and magnitude
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c_in[k]   = {p_ff[2*k][P_W-1], p_ff[2*k]} - {p_ff[2*k+1][P_W-1], p_ff[2*k+1]};
         mag_in[k] = c_in[k][C_W-1] ? (~c_in[k] + 1'b1) : c_in[k];
      end
   end

   // advance the three stages together
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            e1_ff[k]  <= e1_in[k];
            e2_ff[k]  <= e2_in[k];
            mag_ff[k] <= mag_in[k];
            neg_ff[k] <= c_in[k][C_W-1];
         end
         for (int k = 0; k < 6; k++) begin
            p_ff[k] <= p_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_vld};
      end
   end

   assign out_vld = vld_ff[2];
   assign out_mag = mag_ff;
   assign out_neg = neg_ff;
endmodule
`default_nettype wire

>>> rtl/core/tfn_norm.sv
// Common normalizing shift of the cross magnitudes and sum of squares, four stages.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfn_norm import tfn_pkg::*; #(
   parameter int COORD_BITS = TFN_COORD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_vld,
   input  logic [2*COORD_BITS+2:0]   in_mag [3],
   input  logic [2:0]                in_neg,
   output logic                      out_vld,
   output logic [TFN_S_W-1:0]        out_sum,
   output tfn_lane_type              out_lane
);
   localparam int C_W  = 2 * COORD_BITS + 3;
   localparam int LZ_W = $clog2(C_W);
   localparam int X_W  = C_W + TFN_M_W;

   logic [C_W-1:0]          or_v;
   logic [LZ_W-1:0]         lz_in;
   logic [C_W-1:0]          mag_ff [3];
   logic [LZ_W-1:0]         lz_ff;
   tfn_side_type            side_a_ff;
   logic [2:0][TFN_M_W-1:0] m_in;
   tfn_lane_type            lane_b_ff;
   logic [2*TFN_M_W-1:0]    sq_in [3];
   logic [2*TFN_M_W-1:0]    sq_ff [3];
   tfn_lane_type            lane_c_ff;
   logic [TFN_S_W-1:0]      sum_in;
   logic [TFN_S_W-1:0]      sum_ff;
   tfn_lane_type            lane_d_ff;
   logic [3:0]              vld_ff;

   // leading one position over the OR of the three magnitudes
   always_comb begin
      or_v  = in_mag[0] | in_mag[1] | in_mag[2];
      lz_in = '0;
      for (int i = 0; i < C_W; i++) begin
         if (or_v[i]) begin
            lz_in = LZ_W'(C_W - 1 - i);
         end
      end
   end

   // shift so the largest magnitude lands with its top bit at bit 30
   always_comb begin
      logic [X_W-1:0] x;
      for (int k = 0; k < 3; k++) begin
         x       = {mag_ff[k], {TFN_M_W{1'b0}}} << lz_ff;
         m_in[k] = x[X_W-1 -: TFN_M_W];
      end
   end

   // squares, then their sum
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = lane_b_ff.m[k] * lane_b_ff.m[k];
      end
      sum_in = TFN_S_W'(sq_ff[0]) + TFN_S_W'(sq_ff[1]) + TFN_S_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff          <= in_mag;
         lz_ff           <= lz_in;
         side_a_ff.neg   <= in_neg;
         side_a_ff.degen <= (or_v == '0);
         lane_b_ff.side  <= side_a_ff;
         lane_b_ff.m     <= m_in;
         sq_ff           <= sq_in;
         lane_c_ff       <= lane_b_ff;
         sum_ff          <= sum_in;
         lane_d_ff       <= lane_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_vld};
      end
   end

   assign out_vld  = vld_ff[3];
   assign out_sum  = sum_ff;
   assign out_lane = lane_d_ff;
endmodule
`default_nettype wire

>>> rtl/core/tfn_isqrt.sv
// Pipelined integer square root, one result bit per stage (32 stages).
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfn_isqrt import tfn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  logic [TFN_S_W-1:0] in_sum,
   input  tfn_lane_type       in_lane,
   output logic               out_vld,
   output logic [TFN_L_W-1:0] out_root,
   output tfn_lane_type       out_lane
);
   localparam int R_W = TFN_L_W + 2;

   logic [R_W-1:0]     rem_ff  [TFN_SQRT_STAGES];
   logic [TFN_L_W-1:0] root_ff [TFN_SQRT_STAGES];
   logic [TFN_S_W-1:0] s_ff    [TFN_SQRT_STAGES];
   tfn_lane_type       lane_ff [TFN_SQRT_STAGES];
   logic [TFN_SQRT_STAGES-1:0] vld_ff;

   for (genvar g = 0; g < TFN_SQRT_STAGES; g++) begin : g_stage
      logic [R_W-1:0]     rem_p;
      logic [TFN_L_W-1:0] root_p;
      logic [TFN_S_W-1:0] s_p;
      tfn_lane_type       lane_p;
      logic [R_W+1:0]     cat;
      logic [R_W+1:0]     trial;
      logic               ge;

      if (g == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign s_p    = in_sum;
         assign lane_p = in_lane;
      end else begin : g_next
         assign rem_p  = rem_ff[g-1];
         assign root_p = root_ff[g-1];
         assign s_p    = s_ff[g-1];
         assign lane_p = lane_ff[g-1];
      end

      // bring down two bits, try subtracting 4*root + 1
      assign cat   = {rem_p, s_p[TFN_S_W-1 -: 2]};
      assign trial = {2'b00, root_p, 2'b01};
      assign ge    = (cat >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= ge ? R_W'(cat - trial) : cat[R_W-1:0];
            root_ff[g] <= {root_p[TFN_L_W-2:0], ge};
            s_ff[g]    <= s_p << 2;
            lane_ff[g] <= lane_p;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TFN_SQRT_STAGES-2:0], in_vld};
      end
   end

   assign out_vld  = vld_ff[TFN_SQRT_STAGES-1];
   assign out_root = root_ff[TFN_SQRT_STAGES-1];
   assign out_lane = lane_ff[TFN_SQRT_STAGES-1];
endmodule
`default_nettype wire

>>> rtl/core/tfn_div.sv
// Three-lane pipelined restoring divider: round(m * 2^14 / L), one quotient bit a stage.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfn_div import tfn_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_vld,
   input  logic [TFN_L_W-1:0]     in_root,
   input  tfn_lane_type           in_lane,
   output logic                   out_vld,
   output logic [2:0][TFN_Q_W-1:0] out_q,
   output tfn_side_type           out_side
);
   localparam int NS = TFN_DIV_STAGES + 1;

   logic [2:0][TFN_DIV_W-1:0] rem_ff  [NS];
   logic [2:0][TFN_Q_W-1:0]   q_ff    [NS];
   logic [TFN_L_W-1:0]        l_ff    [NS];
   tfn_side_type              side_ff [NS];
   logic [NS-1:0]             vld_ff;

   // dividend with half the divisor added for round half up
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            rem_ff[0][k] <= {in_lane.m[k], TFN_FRAC'(0)}
                            + TFN_DIV_W'(in_root >> 1);
         end
         q_ff[0]    <= '0;
         l_ff[0]    <= in_root;
         side_ff[0] <= in_lane.side;
      end
   end

   for (genvar g = 1; g < NS; g++) begin : g_stage
      localparam int B = TFN_DIV_STAGES - g;
      logic [TFN_DIV_W-1:0] sub;
      logic [2:0]           ge;

      assign sub = TFN_DIV_W'(l_ff[g-1]) << B;

      // compare and subtract the shifted divisor in each lane
      always_comb begin
         for (int k = 0; k < 3; k++) begin
            ge[k] = (rem_ff[g-1][k] >= sub);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int k = 0; k < 3; k++) begin
               rem_ff[g][k] <= ge[k] ? rem_ff[g-1][k] - sub : rem_ff[g-1][k];
               q_ff[g][k]   <= {q_ff[g-1][k][TFN_Q_W-2:0], ge[k]};
            end
            l_ff[g]    <= l_ff[g-1];
            side_ff[g] <= side_ff[g-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NS-2:0], in_vld};
      end
   end

   assign out_vld  = vld_ff[NS-1];
   assign out_q    = q_ff[NS-1];
   assign out_side = side_ff[NS-1];
endmodule
`default_nettype wire

>>> rtl/core/triangle_face_normal_top.sv
// Top level of the triangle face normal pipeline with its output register and skid stage.
// Depends on tfn_pkg, tfn_cross, tfn_norm, tfn_isqrt and tfn_div.
//
// Usage:
//   req channel: one triangle per item, nine signed coordinates with 12 fraction
//   bits packed in req_tdata (a_x lowest, then a_y ... c_z).
//   rsp channel: one result per item, the unit normal in Q1.14 in rsp_tdata
//   (normal_x lowest) and the degenerate flag in rsp_tuser; a degenerate
//   triangle gives an all-zero normal.
//   Path: cross product, normalize and sum of squares, square root (one bit per
//   stage), divide (a preload stage, then one quotient bit per stage), output
//   register. Throughput: one item per cycle while the skid register is empty;
//   every stage is a register stage.
//   Stall: when rsp_tready is low the output register holds and the next item
//   drops into a skid register; req_tready then falls and the whole pipeline
//   freezes until the skid empties. Nothing is lost or repeated.
//   Reset: synchronous, clears all valid bits; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module triangle_face_normal_top import tfn_pkg::*; #(
   parameter int  COORD_BITS = TFN_COORD_BITS,
   localparam int REQ_W      = ((9 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero pad
   input  logic [REQ_W-1:0]     req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // normal_x, normal_y, normal_z
   output logic [3*TFN_N_W-1:0] rsp_tdata,
   // degenerate
   output logic                 rsp_tuser
);
   localparam int C_W = 2 * COORD_BITS + 3;

   logic                      en;
   logic                      cr_vld;
   logic [C_W-1:0]            cr_mag [3];
   logic [2:0]                cr_neg;
   logic                      nm_vld;
   logic [TFN_S_W-1:0]        nm_sum;
   tfn_lane_type              nm_lane;
   logic                      sq_vld;
   logic [TFN_L_W-1:0]        sq_root;
   tfn_lane_type              sq_lane;
   logic                      dv_vld;
   logic [2:0][TFN_Q_W-1:0]   dv_q;
   tfn_side_type              dv_side;
   logic [3*TFN_N_W-1:0]      res_data;
   logic                      out_take;
   logic                      rsp_vld_ff;
   logic [3*TFN_N_W-1:0]      rsp_data_ff;
   logic                      rsp_user_ff;
   logic                      skid_vld_ff;
   logic [3*TFN_N_W-1:0]      skid_data_ff;
   logic                      skid_user_ff;

   // pipeline advances whenever the skid register is empty
   assign en         = !skid_vld_ff;
   assign req_tready = en;

   tfn_cross #(.COORD_BITS(COORD_BITS)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_vld    (req_tvalid),
      .in_coords (req_tdata[9*COORD_BITS-1:0]),
      .out_vld   (cr_vld),
      .out_mag   (cr_mag),
      .out_neg   (cr_neg)
   );

   tfn_norm #(.COORD_BITS(COORD_BITS)) u_norm (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (cr_vld),
      .in_mag   (cr_mag),
      .in_neg   (cr_neg),
      .out_vld  (nm_vld),
      .out_sum  (nm_sum),
      .out_lane (nm_lane)
   );

   tfn_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (nm_vld),
      .in_sum   (nm_sum),
      .in_lane  (nm_lane),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_lane (sq_lane)
   );

   tfn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (sq_vld),
      .in_root  (sq_root),
      .in_lane  (sq_lane),
      .out_vld  (dv_vld),
      .out_q    (dv_q),
      .out_side (dv_side)
   );

   // apply signs, zero the normal of a degenerate triangle
   always_comb begin
      logic [TFN_N_W-1:0] n;
      for (int k = 0; k < 3; k++) begin
         n = {1'b0, dv_q[k]};
         if (dv_side.neg[k]) begin
            n = ~n + 1'b1;
         end
         if (dv_side.degen) begin
            n = '0;
         end
         res_data[k*TFN_N_W +: TFN_N_W] = n;
      end
   end

   assign out_take = !rsp_vld_ff || rsp_tready;

   // output register and skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_take) begin
         rsp_vld_ff  <= skid_vld_ff || dv_vld;
         skid_vld_ff <= 1'b0;
      end else if (dv_vld && en) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         rsp_data_ff <= skid_vld_ff ? skid_data_ff : res_data;
         rsp_user_ff <= skid_vld_ff ? skid_user_ff : dv_side.degen;
      end else if (en) begin
         skid_data_ff <= res_data;
         skid_user_ff <= dv_side.degen;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule
`default_nettype wire

>>> rtl/core/tfn_checker.sv
// Port-level checks on the triangle face normal top level, bound to it below.
// Depends on tfn_pkg and triangle_face_normal_top.
`timescale 1ns / 1ps
`default_nettype none
module tfn_checker import tfn_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_tvalid,
   input wire logic                 req_tready,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [3*TFN_N_W-1:0] rsp_tdata,
   input wire logic                 rsp_tuser
);
   localparam logic signed [TFN_N_W-1:0] ONE  = TFN_N_W'(1 << TFN_FRAC);
   localparam logic signed [TFN_N_W-1:0] MONE = -ONE;

   logic signed [TFN_N_W-1:0] nx, ny, nz;
   assign nx = rsp_tdata[TFN_N_W-1:0];
   assign ny = rsp_tdata[2*TFN_N_W-1:TFN_N_W];
   assign nz = rsp_tdata[3*TFN_N_W-1:2*TFN_N_W];

   // hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // degenerate results carry a zero normal
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate result with nonzero normal");

   // components stay within unit range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> nx <= ONE && nx >= MONE && ny <= ONE && ny >= MONE
                     && nz <= ONE && nz >= MONE)
      else $error("normal component out of range");

   // input side only blocks while a result is pending
   a_block: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input blocked with no pending result");

   // a blocked input with a waiting request stays blocked while the output is stalled
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !req_tready && !rsp_tready && req_tvalid |=> !req_tready)
      else $error("input freed while output stalled");
endmodule

bind triangle_face_normal_top tfn_checker u_tfn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
